// ===== rtl/htfc_pkg.sv =====
`timescale 1ns / 1ps

package htfc_pkg;

  // crc-8, polynomial x^8+x^5+x^4+1, msb first
  localparam logic [7:0]  CRC_POLY       = 8'h31;
  localparam logic [15:0] RAW_ERROR      = 16'hFFFF;
  localparam logic [15:0] HUM_TOGGLE     = 16'h0002;

  // conversion scales, value = floor(raw * scale / 65536) - offset
  localparam int          SCALE_W        = 15;
  localparam int          PROD_W         = 16 + SCALE_W;
  localparam int          PROD_HI_W      = PROD_W - 16;
  localparam logic [SCALE_W-1:0] TEMP_SCALE = 15'd17572;
  localparam logic [SCALE_W-1:0] HUM_SCALE  = 15'd12500;

  localparam int          DIFF_W         = PROD_HI_W + 2;
  localparam logic signed [DIFF_W-1:0] TEMP_OFFSET = 17'sd4685;
  localparam logic signed [DIFF_W-1:0] HUM_OFFSET  = 17'sd600;
  localparam logic signed [DIFF_W-1:0] HUM_MAX     = 17'sd10000;
  localparam logic signed [15:0] TEMP_ERROR_VALUE  = 16'sd25500;
  localparam logic signed [15:0] HUM_ERROR_VALUE   = 16'sd0;

  // measurement kind
  localparam logic OP_TEMP = 1'b0;
  localparam logic OP_HUM  = 1'b1;

  // beat handed to the value stage
  typedef struct packed {
    logic                 op;
    logic                 all_ones;
    logic [7:0]           crc;
    logic [7:0]           chk;
    logic [PROD_HI_W-1:0] prod_hi;
  } conv_beat_t;

  // one byte through the crc register
  function automatic logic [7:0] crc_byte(input logic [7:0] d);
    logic [7:0] c;
    c = d;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/htfc_value_stage.sv =====
`timescale 1ns / 1ps

module htfc_value_stage (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     beat_valid,
  output logic                     beat_ready,
  input  htfc_pkg::conv_beat_t     beat,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [15:0]       value,
  output logic                     error
);

  logic                                     err;
  logic signed [htfc_pkg::DIFF_W-1:0]       prod_s;
  logic signed [htfc_pkg::DIFF_W-1:0]       temp_diff;
  logic signed [htfc_pkg::DIFF_W-1:0]       hum_diff;
  logic signed [15:0]                       value_next;

  assign beat_ready = !out_valid || out_ready;

  // frame check and offset / clamp
  always_comb begin
    err       = (beat.crc != beat.chk) || beat.all_ones;
    prod_s    = $signed({2'b00, beat.prod_hi});
    temp_diff = prod_s - htfc_pkg::TEMP_OFFSET;
    hum_diff  = prod_s - htfc_pkg::HUM_OFFSET;
    if (beat.op == htfc_pkg::OP_TEMP) begin
      if (err) begin
        value_next = htfc_pkg::TEMP_ERROR_VALUE;
      end else begin
        value_next = temp_diff[15:0];
      end
    end else begin
      if (err) begin
        value_next = htfc_pkg::HUM_ERROR_VALUE;
      end else if (hum_diff < 0) begin
        value_next = 16'sd0;
      end else if (hum_diff > htfc_pkg::HUM_MAX) begin
        value_next = htfc_pkg::HUM_MAX[15:0];
      end else begin
        value_next = hum_diff[15:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (beat_ready) begin
      out_valid <= beat_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (beat_ready && beat_valid) begin
      value <= value_next;
      error <= err;
    end
  end

endmodule

// ===== rtl/humidity_temp_frame_convert_top.sv =====
`timescale 1ns / 1ps

// Checks one received humidity or temperature frame (two data bytes and a
// crc-8 byte, polynomial 0x31, init 0) and converts the 16-bit raw value to
// hundredths of a degree Celsius or of percent relative humidity. A frame with
// a bad checksum or a raw value of all ones is flagged in error, with value
// 25500 for temperature and 0 for humidity. The block is a three-stage
// pipeline (crc of the high byte and operand select, crc of the low byte and
// the scale multiply, then check, offset and clamp into the output register):
// it takes one frame per clock as long as the output side keeps taking beats,
// and each frame passes through the stage a, stage b and output registers.
module humidity_temp_frame_convert_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               operation,
  input  logic [7:0]         high_byte,
  input  logic [7:0]         low_byte,
  input  logic [7:0]         check_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] value,
  output logic               error
);

  // stage a registers
  logic                              a_valid;
  logic                              a_op;
  logic                              a_all_ones;
  logic [7:0]                        a_crc_hi;
  logic [7:0]                        a_lo;
  logic [7:0]                        a_chk;
  logic [15:0]                       a_operand;
  logic [htfc_pkg::SCALE_W-1:0]      a_scale;
  logic                              a_ready;

  // stage b registers
  logic                              b_valid;
  htfc_pkg::conv_beat_t              b_beat;
  logic                              b_ready;

  logic [15:0]                       raw;
  logic [htfc_pkg::PROD_W-1:0]       product;

  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;
  assign raw      = {high_byte, low_byte};

  // stage a: high byte crc, operand and scale select
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_op       <= operation;
      a_all_ones <= (raw == htfc_pkg::RAW_ERROR);
      a_crc_hi   <= htfc_pkg::crc_byte(high_byte);
      a_lo       <= low_byte;
      a_chk      <= check_byte;
      if (operation == htfc_pkg::OP_HUM) begin
        a_operand <= raw ^ htfc_pkg::HUM_TOGGLE;
        a_scale   <= htfc_pkg::HUM_SCALE;
      end else begin
        a_operand <= raw;
        a_scale   <= htfc_pkg::TEMP_SCALE;
      end
    end
  end

  // stage b: low byte crc and scale multiply
  assign product = a_operand * a_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      b_beat.op       <= a_op;
      b_beat.all_ones <= a_all_ones;
      b_beat.crc      <= htfc_pkg::crc_byte(a_crc_hi ^ a_lo);
      b_beat.chk      <= a_chk;
      b_beat.prod_hi  <= product[htfc_pkg::PROD_W-1:16];
    end
  end

  // stage c: check, offset, clamp, output register
  htfc_value_stage u_value (
    .clk        (clk),
    .rst        (rst),
    .beat_valid (b_valid),
    .beat_ready (b_ready),
    .beat       (b_beat),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value),
    .error      (error)
  );

endmodule

// ===== tb/tb_humidity_temp_frame_convert_top.sv =====
`timescale 1ns / 1ps

module tb_humidity_temp_frame_convert_top;

  // conversion constants, hundredths
  localparam int unsigned T_GAIN    = 17572;
  localparam int          T_SHIFT   = 4685;
  localparam int          T_BAD_VAL = 25500;
  localparam int unsigned H_GAIN    = 12500;
  localparam int          H_SHIFT   = 600;
  localparam int          H_CEIL    = 10000;
  localparam logic [15:0] RAW_ALL_ONES = 16'hFFFF;
  localparam logic [15:0] H_FLIP       = 16'h0002;
  localparam int          FRAMES_PER_PHASE = 125;

  typedef struct {
    logic       op;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] chk;
  } frame_t;

  typedef struct {
    logic signed [15:0] value;
    logic               error;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic operation = 1'b0;
  logic [7:0] high_byte = 8'h00;
  logic [7:0] low_byte = 8'h00;
  logic [7:0] check_byte = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] value;
  logic error;

  frame_t   pending_frames[$];
  reading_t expected_readings[$];
  frame_t   next_frame;
  reading_t want;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int frames_accepted = 0;
  int readings_checked = 0;
  int temp_frames = 0;
  int hum_frames = 0;
  int flagged_frames = 0;

  humidity_temp_frame_convert_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .high_byte (high_byte),
    .low_byte  (low_byte),
    .check_byte(check_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .error     (error)
  );

  always #5 clk = ~clk;

  // crc-8 over the 16-bit raw word, poly 0x31, init 0, msb first
  function automatic logic [7:0] frame_crc8(input logic [15:0] raw);
    logic [15:0] r;
    r = raw;
    for (int i = 0; i < 16; i++) begin
      if (r[15]) begin
        r = {r[14:0], 1'b0} ^ {htfc_pkg::CRC_POLY, 8'h00};
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r[15:8];
  endfunction

  // expected reading for one frame
  function automatic reading_t convert_frame(input logic op, input logic [7:0] hi,
                                             input logic [7:0] lo, input logic [7:0] chk);
    reading_t    r;
    logic [15:0] raw;
    int unsigned prod;
    int          v;
    raw = {hi, lo};
    r.error = (frame_crc8(raw) != chk) || (raw == RAW_ALL_ONES);
    if (op == htfc_pkg::OP_TEMP) begin
      if (r.error) begin
        v = T_BAD_VAL;
      end else begin
        prod = 32'(raw) * T_GAIN;
        v = int'(prod >> 16) - T_SHIFT;
      end
    end else begin
      if (r.error) begin
        v = 0;
      end else begin
        prod = 32'(raw ^ H_FLIP) * H_GAIN;
        v = int'(prod >> 16) - H_SHIFT;
        if (v < 0) begin
          v = 0;
        end else if (v > H_CEIL) begin
          v = H_CEIL;
        end
      end
    end
    r.value = v[15:0];
    return r;
  endfunction

  // queue a frame; crc_flip of zero gives a matching checksum
  task automatic add_frame(input logic op, input logic [15:0] raw, input logic [7:0] crc_flip);
    frame_t f;
    f.op = op;
    f.hi = raw[15:8];
    f.lo = raw[7:0];
    f.chk = frame_crc8(raw) ^ crc_flip;
    pending_frames.push_back(f);
  endtask

  task automatic add_random_frame();
    logic [15:0] raw;
    logic [7:0]  flip;
    case ($urandom_range(9))
      0: raw = 16'($urandom_range(0, 4095));
      1: raw = 16'hF000 | 16'($urandom_range(0, 4095));
      default: raw = 16'($urandom);
    endcase
    flip = ($urandom_range(99) < 80) ? 8'h00 : 8'($urandom_range(1, 255));
    add_frame(1'($urandom), raw, flip);
  endtask

  // wait until the sender and the pipeline have drained
  task automatic wait_drained();
    while (pending_frames.size() != 0 || expected_readings.size() != 0 || in_valid) begin
      @(negedge clk);
    end
    @(negedge clk);
  endtask

  // input beat driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        want = convert_frame(operation, high_byte, low_byte, check_byte);
        expected_readings.push_back(want);
        frames_accepted++;
        if (operation == htfc_pkg::OP_TEMP) temp_frames++;
        else hum_frames++;
        if (want.error) flagged_frames++;
      end
      if (!in_valid || in_ready) begin
        if (pending_frames.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_frame = pending_frames.pop_front();
          in_valid   <= 1'b1;
          operation  <= next_frame.op;
          high_byte  <= next_frame.hi;
          low_byte   <= next_frame.lo;
          check_byte <= next_frame.chk;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output beat monitor and stall generator
  always @(posedge clk) begin
    reading_t got_exp;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          $error("unexpected reading: value %0d error %0b", value, error);
          mismatches++;
        end else begin
          got_exp = expected_readings.pop_front();
          readings_checked++;
          if (value !== got_exp.value) begin
            $error("value mismatch: expected %0d, got %0d", got_exp.value, value);
            mismatches++;
          end
          if (error !== got_exp.error) begin
            $error("error mismatch: expected %0b, got %0b", got_exp.error, error);
            mismatches++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // stimulus and phase sequencing
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed frames: field extremes, checksum and clamp corners
    add_frame(htfc_pkg::OP_TEMP, 16'h0000, 8'h00);   // coldest reading
    add_frame(htfc_pkg::OP_TEMP, 16'hFFFE, 8'h00);   // hottest valid reading
    add_frame(htfc_pkg::OP_TEMP, 16'hFFFF, 8'h00);   // all ones, crc good
    add_frame(htfc_pkg::OP_HUM,  16'hFFFF, 8'h00);
    add_frame(htfc_pkg::OP_TEMP, 16'hFFFF, 8'h5A);   // all ones, crc bad
    add_frame(htfc_pkg::OP_HUM,  16'hFFFF, 8'hA5);
    add_frame(htfc_pkg::OP_TEMP, 16'h6A3C, 8'h01);   // checksum mismatch
    add_frame(htfc_pkg::OP_HUM,  16'h6A3C, 8'h80);
    add_frame(htfc_pkg::OP_TEMP, 16'h8000, 8'hFF);
    add_frame(htfc_pkg::OP_HUM,  16'h0000, 8'h00);   // humidity clamps low
    add_frame(htfc_pkg::OP_HUM,  16'h0002, 8'h00);   // toggled bit gives operand zero
    add_frame(htfc_pkg::OP_HUM,  16'h0C4A, 8'h00);   // just around zero percent
    add_frame(htfc_pkg::OP_HUM,  16'hFFFE, 8'h00);   // humidity clamps high
    add_frame(htfc_pkg::OP_HUM,  16'hFFFD, 8'h00);
    add_frame(htfc_pkg::OP_HUM,  16'hD915, 8'h00);   // right at 100 percent
    add_frame(htfc_pkg::OP_HUM,  16'h8000, 8'h00);
    add_frame(htfc_pkg::OP_HUM,  16'h7FFF, 8'h00);
    add_frame(htfc_pkg::OP_TEMP, 16'h7FFF, 8'h00);
    add_frame(htfc_pkg::OP_TEMP, 16'h00FF, 8'h00);
    add_frame(htfc_pkg::OP_TEMP, 16'hFF00, 8'h00);
    add_frame(htfc_pkg::OP_HUM,  16'h5555, 8'h00);
    add_frame(htfc_pkg::OP_TEMP, 16'hAAAA, 8'h00);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
        add_random_frame();
      end
      // sender holds off here until every reading is back
      wait_drained();
    end

    repeat (10) @(posedge clk);
    $display("run covered %0d frames (%0d temperature, %0d humidity), %0d flagged in error",
             frames_accepted, temp_frames, hum_frames, flagged_frames);
    $display("readings checked: %0d, mismatches: %0d", readings_checked, mismatches);
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
